[rtl/polyline_projection_arc_length_defines.svh]
// ----------------------------------------------------------------------------
// polyline projection arc length - assertion macros
// shared property forms for the block-level checks
// ----------------------------------------------------------------------------
`ifndef POLYLINE_PROJECTION_ARC_LENGTH_DEFINES_SVH
`define POLYLINE_PROJECTION_ARC_LENGTH_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PPAL_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define PPAL_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ppal_pkg.sv]
// ----------------------------------------------------------------------------
// ppal_pkg
// types, widths and codes shared by the polyline projection block
// ----------------------------------------------------------------------------
package ppal_pkg;

    // path storage
    localparam int MAX_POINTS      = 1024;
    localparam int AW              = $clog2(MAX_POINTS);
    localparam int CW              = $clog2(MAX_POINTS + 1);

    // fixed point widths
    localparam int RATIO_FRAC_BITS = 16;
    localparam int COORD_W         = 32;
    localparam int DIFF_W          = COORD_W + 1;
    localparam int MAG_W           = COORD_W;
    localparam int PROD_W          = 2 * MAG_W;
    localparam int LEN_W           = PROD_W + 2;
    localparam int DOT_W           = PROD_W + 3;
    localparam int RATIO_W         = RATIO_FRAC_BITS + 1;
    localparam int EX_W            = DIFF_W + RATIO_W;
    localparam int EL              = (EX_W + 1) / 2;
    localparam int DIST_W          = 2 * EX_W;
    localparam int SL_W            = LEN_W / 2;
    localparam int ARC_W           = 32;
    localparam int RCNT_W          = $clog2(RATIO_FRAC_BITS);

    // item queue
    localparam int QDEPTH          = 4;
    localparam int QAW             = $clog2(QDEPTH);
    localparam int QCW             = $clog2(QDEPTH + 1);

    // multiply sequence steps
    localparam int STEP_W          = 4;
    localparam logic [STEP_W-1:0] ST_DXX  = 4'd0;
    localparam logic [STEP_W-1:0] ST_DYY  = 4'd1;
    localparam logic [STEP_W-1:0] ST_UXDX = 4'd2;
    localparam logic [STEP_W-1:0] ST_UYDY = 4'd3;
    localparam logic [STEP_W-1:0] ST_XHH  = 4'd4;
    localparam logic [STEP_W-1:0] ST_XHL  = 4'd5;
    localparam logic [STEP_W-1:0] ST_XLL  = 4'd6;
    localparam logic [STEP_W-1:0] ST_YHH  = 4'd7;
    localparam logic [STEP_W-1:0] ST_YHL  = 4'd8;
    localparam logic [STEP_W-1:0] ST_YLL  = 4'd9;

    // item kinds
    typedef enum logic [1:0] {
        K_CLEAR  = 2'd0,
        K_APPEND = 2'd1,
        K_QUERY  = 2'd2
    } t_kind;
    localparam logic [1:0] KIND_BAD = 2'd3;

    typedef struct packed {
        t_kind                     kind;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    typedef enum logic [3:0] {
        S_IDLE, S_LOADA, S_LOADB, S_DIFF, S_MUL, S_RCHK, S_DIV,
        S_EXY, S_SQRT, S_ARC, S_UPD, S_DONE
    } t_state;

endpackage

[rtl/ppal_front.sv]
// ----------------------------------------------------------------------------
// ppal_front
// accepts input beats, drops unknown kinds, queues items for the back end
// ----------------------------------------------------------------------------
module ppal_front import ppal_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_kind,
    input  logic signed [COORD_W-1:0] i_x,
    input  logic signed [COORD_W-1:0] i_y,
    output t_qhead                    o_head,
    input  logic                      i_pop
);

    t_item            r_q [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QCW-1:0]   r_cnt, n_cnt;
    logic             push;

    // classify: unknown kinds are taken and dropped
    assign o_ready = (r_cnt != QCW'(QDEPTH));
    assign push    = i_valid && o_ready && (i_kind != KIND_BAD);

    // occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{kind: t_kind'(i_kind), x: i_x, y: i_y};
        end
    end

    // head of queue
    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_q[r_rp];

endmodule

[rtl/ppal_back.sv]
// ----------------------------------------------------------------------------
// ppal_back
// path memories and the per-segment projection sequencer
// ----------------------------------------------------------------------------
module ppal_back import ppal_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_qhead           i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [ARC_W-1:0] o_arc_length,
    output logic [CW-1:0]    o_points_used
);

    // path memories
    logic signed [COORD_W-1:0] mem_x [MAX_POINTS];
    logic signed [COORD_W-1:0] mem_y [MAX_POINTS];
    logic signed [COORD_W-1:0] r_mx, r_my;

    t_state r_state, n_state;
    logic [CW-1:0]               r_count, r_pts;
    logic [AW-1:0]               r_idx, rd_addr;
    logic                        start, wr_en;
    logic signed [COORD_W-1:0]   r_ax, r_ay, r_bx, r_by, r_qx, r_qy;
    logic signed [DIFF_W-1:0]    r_dx, r_dy, r_ux, r_uy;
    logic [LEN_W-1:0]            r_len;
    logic signed [DOT_W-1:0]     r_dot;
    logic [DOT_W-1:0]            dot_u, r_rem, rem2, len_e, prod_e;
    logic [RATIO_W-1:0]          r_ratio;
    logic [RCNT_W-1:0]           r_cnt;
    logic [EX_W-1:0]             r_exm, r_eym;
    logic signed [EX_W-1:0]      ex_s, ey_s;
    logic [DIST_W-1:0]           r_dist, r_best, dist_p;
    logic                        r_have;
    logic [ARC_W-1:0]            r_cum, r_best_arc;
    logic [LEN_W:0]              r_sq_op, r_sq_res, r_sq_one, sq_trial;
    logic [SL_W-1:0]             seg_len, part;
    logic [SL_W:0]               arc_sum, cum_sum;
    logic [ARC_W-1:0]            arc_sat, cum_sat;
    logic [RATIO_W+SL_W-1:0]     r_prod2;
    logic [PROD_W-1:0]           r_prod;
    logic [MAG_W-1:0]            mul_a, mul_b, dxm, dym, uxm, uym;
    logic [MAG_W-1:0]            exh, exl, eyh, eyl;
    logic [STEP_W-1:0]           r_step;
    logic                        r_ph, more, prod_neg;
    logic                        r_out_valid;
    logic [ARC_W-1:0]            r_out_arc;
    logic [CW-1:0]               r_out_pts;

    // queue head may run: a query needs the output register free
    assign start = i_head.valid && (i_head.item.kind != K_QUERY || !r_out_valid);

    // another segment after the current one
    assign more = ((CW+1)'(r_idx) + (CW+1)'(2)) < (CW+1)'(r_count);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start && i_head.item.kind == K_QUERY) begin
                    n_state = (r_count < CW'(2)) ? S_DONE : S_LOADA;
                end
            end
            S_LOADA: n_state = S_LOADB;
            S_LOADB: n_state = S_DIFF;
            S_DIFF:  n_state = S_MUL;
            S_MUL: begin
                if (r_ph && r_step == ST_UYDY) begin
                    n_state = S_RCHK;
                end else if (r_ph && r_step == ST_YLL) begin
                    n_state = S_SQRT;
                end
            end
            S_RCHK: begin
                if (r_len == '0 || r_dot <= 0 || dot_u >= len_e) begin
                    n_state = S_EXY;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == RCNT_W'(RATIO_FRAC_BITS - 1)) begin
                    n_state = S_EXY;
                end
            end
            S_EXY: n_state = S_MUL;
            S_SQRT: begin
                if (r_sq_one == (LEN_W+1)'(1)) begin
                    n_state = S_ARC;
                end
            end
            S_ARC:  n_state = S_UPD;
            S_UPD:  n_state = more ? S_LOADB : S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: pop, memory addresses
    always_comb begin
        o_pop   = (r_state == S_IDLE) && start;
        wr_en   = o_pop && (i_head.item.kind == K_APPEND) && (r_count < CW'(MAX_POINTS));
        case (r_state)
            S_LOADA: rd_addr = r_idx + AW'(1);
            S_UPD:   rd_addr = r_idx + AW'(2);
            default: rd_addr = '0;
        endcase
    end

    // operand magnitudes
    assign dxm = r_dx[DIFF_W-1] ? MAG_W'(-r_dx) : MAG_W'(r_dx);
    assign dym = r_dy[DIFF_W-1] ? MAG_W'(-r_dy) : MAG_W'(r_dy);
    assign uxm = r_ux[DIFF_W-1] ? MAG_W'(-r_ux) : MAG_W'(r_ux);
    assign uym = r_uy[DIFF_W-1] ? MAG_W'(-r_uy) : MAG_W'(r_uy);
    assign exh = MAG_W'(r_exm[EX_W-1:EL]);
    assign exl = MAG_W'(r_exm[EL-1:0]);
    assign eyh = MAG_W'(r_eym[EX_W-1:EL]);
    assign eyl = MAG_W'(r_eym[EL-1:0]);

    // shared multiplier operand select
    always_comb begin
        case (r_step)
            ST_DXX:  begin mul_a = dxm; mul_b = dxm; end
            ST_DYY:  begin mul_a = dym; mul_b = dym; end
            ST_UXDX: begin mul_a = uxm; mul_b = dxm; end
            ST_UYDY: begin mul_a = uym; mul_b = dym; end
            ST_XHH:  begin mul_a = exh; mul_b = exh; end
            ST_XHL:  begin mul_a = exh; mul_b = exl; end
            ST_XLL:  begin mul_a = exl; mul_b = exl; end
            ST_YHH:  begin mul_a = eyh; mul_b = eyh; end
            ST_YHL:  begin mul_a = eyh; mul_b = eyl; end
            ST_YLL:  begin mul_a = eyl; mul_b = eyl; end
            default: begin mul_a = '0;  mul_b = '0;  end
        endcase
    end

    // dot product sign of the current step
    assign prod_neg = (r_step == ST_UXDX) ? (r_ux[DIFF_W-1] ^ r_dx[DIFF_W-1])
                                          : (r_uy[DIFF_W-1] ^ r_dy[DIFF_W-1]);
    assign prod_e   = DOT_W'(r_prod);
    assign dot_u    = r_dot;
    assign len_e    = DOT_W'(r_len);
    assign rem2     = {r_rem[DOT_W-2:0], 1'b0};

    // squared distance term of the current step
    always_comb begin
        case (r_step)
            ST_XHH, ST_YHH: dist_p = DIST_W'(r_prod) << (2 * EL);
            ST_XHL, ST_YHL: dist_p = DIST_W'(r_prod) << (EL + 1);
            default:        dist_p = DIST_W'(r_prod);
        endcase
    end

    // error vector from the quantized ratio
    assign ex_s = (EX_W'(r_ux) <<< RATIO_FRAC_BITS)
                - EX_W'(r_dx) * EX_W'($signed({1'b0, r_ratio}));
    assign ey_s = (EX_W'(r_uy) <<< RATIO_FRAC_BITS)
                - EX_W'(r_dy) * EX_W'($signed({1'b0, r_ratio}));

    // square root digit step
    assign sq_trial = r_sq_res + r_sq_one;
    assign seg_len  = r_sq_res[SL_W-1:0];

    // arc candidate and running length, saturating
    assign part    = r_prod2[RATIO_FRAC_BITS +: SL_W];
    assign arc_sum = (SL_W+1)'(r_cum) + (SL_W+1)'(part);
    assign cum_sum = (SL_W+1)'(r_cum) + (SL_W+1)'(seg_len);
    assign arc_sat = (arc_sum > (SL_W+1)'({ARC_W{1'b1}})) ? '1 : arc_sum[ARC_W-1:0];
    assign cum_sat = (cum_sum > (SL_W+1)'({ARC_W{1'b1}})) ? '1 : cum_sum[ARC_W-1:0];

    // memories
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_x[r_count[AW-1:0]] <= i_head.item.x;
            mem_y[r_count[AW-1:0]] <= i_head.item.y;
        end
        r_mx <= mem_x[rd_addr];
        r_my <= mem_y[rd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop && i_head.item.kind == K_CLEAR) begin
                r_count <= '0;
            end else if (wr_en) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == S_DONE) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (o_pop && i_head.item.kind == K_QUERY) begin
                    r_pts      <= r_count;
                    r_qx       <= i_head.item.x;
                    r_qy       <= i_head.item.y;
                    r_have     <= 1'b0;
                    r_best_arc <= '0;
                    r_cum      <= '0;
                    r_idx      <= '0;
                end
            end
            S_LOADA: begin
                r_ax <= r_mx;
                r_ay <= r_my;
            end
            S_LOADB: begin
                r_bx <= r_mx;
                r_by <= r_my;
            end
            S_DIFF: begin
                r_dx   <= DIFF_W'(r_bx) - DIFF_W'(r_ax);
                r_dy   <= DIFF_W'(r_by) - DIFF_W'(r_ay);
                r_ux   <= DIFF_W'(r_qx) - DIFF_W'(r_ax);
                r_uy   <= DIFF_W'(r_qy) - DIFF_W'(r_ay);
                r_step <= ST_DXX;
                r_ph   <= 1'b0;
            end
            S_MUL: begin
                if (!r_ph) begin
                    r_prod <= mul_a * mul_b;
                    r_ph   <= 1'b1;
                end else begin
                    r_ph   <= 1'b0;
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        ST_DXX:  r_len <= LEN_W'(r_prod);
                        ST_DYY:  r_len <= r_len + LEN_W'(r_prod);
                        ST_UXDX: r_dot <= prod_neg ? -$signed(prod_e) : $signed(prod_e);
                        ST_UYDY: r_dot <= prod_neg ? r_dot - $signed(prod_e)
                                                   : r_dot + $signed(prod_e);
                        ST_XHH:  r_dist <= dist_p;
                        default: r_dist <= r_dist + dist_p;
                    endcase
                end
            end
            S_RCHK: begin
                r_sq_op  <= (LEN_W+1)'(r_len);
                r_sq_res <= '0;
                r_sq_one <= (LEN_W+1)'(1) << (LEN_W - 2);
                r_rem    <= dot_u;
                r_cnt    <= '0;
                if (r_len == '0 || r_dot <= 0) begin
                    r_ratio <= '0;
                end else if (dot_u >= len_e) begin
                    r_ratio <= RATIO_W'(1) << RATIO_FRAC_BITS;
                end else begin
                    r_ratio <= '0;
                end
            end
            S_DIV: begin
                r_cnt <= r_cnt + 1'b1;
                if (rem2 >= len_e) begin
                    r_rem   <= rem2 - len_e;
                    r_ratio <= {r_ratio[RATIO_W-2:0], 1'b1};
                end else begin
                    r_rem   <= rem2;
                    r_ratio <= {r_ratio[RATIO_W-2:0], 1'b0};
                end
            end
            S_EXY: begin
                r_exm <= ex_s[EX_W-1] ? EX_W'(-ex_s) : EX_W'(ex_s);
                r_eym <= ey_s[EX_W-1] ? EX_W'(-ey_s) : EX_W'(ey_s);
            end
            S_SQRT: begin
                r_sq_one <= r_sq_one >> 2;
                if (r_sq_op >= sq_trial) begin
                    r_sq_op  <= r_sq_op - sq_trial;
                    r_sq_res <= (r_sq_res >> 1) + r_sq_one;
                end else begin
                    r_sq_res <= r_sq_res >> 1;
                end
            end
            S_ARC: begin
                r_prod2 <= r_ratio * seg_len;
            end
            S_UPD: begin
                if (!r_have || r_dist < r_best) begin
                    r_have     <= 1'b1;
                    r_best     <= r_dist;
                    r_best_arc <= arc_sat;
                end
                r_cum <= cum_sat;
                r_idx <= r_idx + 1'b1;
                r_ax  <= r_bx;
                r_ay  <= r_by;
            end
            S_DONE: begin
                r_out_arc <= r_best_arc;
                r_out_pts <= r_pts;
            end
            default: begin
            end
        endcase
    end

    // result beat
    assign o_valid       = r_out_valid;
    assign o_arc_length  = r_out_arc;
    assign o_points_used = r_out_pts;

endmodule

[rtl/polyline_projection_arc_length.sv]
// ----------------------------------------------------------------------------
// polyline_projection_arc_length
// projects a query point onto a stored polyline and returns its arc length
//
//   channel | valid   | ready   | payload
//   --------+---------+---------+-------------------------------
//   input   | i_valid | o_ready | i_kind, i_x, i_y
//   result  | o_valid | i_ready | o_arc_length, o_points_used
//
// clear and append are carried out by the back end as they leave the 4-deep queue.
// a query walks the segments of an n-point path in turn (none with fewer than
// two points), each through the per-segment sequence: 10 shared 32x32 multiplies,
// a 16-step ratio divide (skipped when clamped) and a 33-step square root.
// reset is synchronous; the path memories need no clearing pass.
// the queue keeps taking beats while a result waits on i_ready, until full.
// ----------------------------------------------------------------------------
`include "polyline_projection_arc_length_defines.svh"

module polyline_projection_arc_length import ppal_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_kind,
    input  logic signed [COORD_W-1:0] i_x,
    input  logic signed [COORD_W-1:0] i_y,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [ARC_W-1:0]          o_arc_length,
    output logic [CW-1:0]             o_points_used
);

    t_qhead w_head;
    logic   w_pop;
    logic   w_pop_query, w_short;

    // accept and classify
    ppal_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_kind  (i_kind),
        .i_x     (i_x),
        .i_y     (i_y),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    // execute
    ppal_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_arc_length  (o_arc_length),
        .o_points_used (o_points_used)
    );

    // check terms
    assign w_pop_query = w_pop && (w_head.item.kind == K_QUERY);
    assign w_short     = o_valid && (o_points_used < CW'(2));

    // checks
    `PPAL_ASSERT_IMPL(a_pop_has_item, w_pop, w_head.valid, "pop from empty queue")
    `PPAL_ASSERT_IMPL(a_query_out_free, w_pop_query, !o_valid, "query with result pending")
    `PPAL_ASSERT_NEXT(a_query_no_early, w_pop_query, !o_valid, "result beat too early")
    `PPAL_ASSERT_IMPL(a_short_path_zero, w_short, o_arc_length == '0, "short path arc")

endmodule
